>>> hw/rtl/jdcm_pkg.sv
// jdcm_pkg: shared types, codes and constants for the joystick drive command mapper
// no dependencies; imported by every module of the block

package jdcm_pkg;

    localparam int MODE_SLOTS_DEF  = 8;
    localparam int NUM_BUTTONS_DEF = 12;
    localparam int NUM_AXES_DEF    = 4;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_DATA_W      = 40;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [4:0] LIMIT_BUTTON    = 5'd4;
    localparam logic [4:0] ENABLE_OFF_MIN  = 5'd12;
    localparam logic [4:0] BUTTON_LIMIT    = 5'd12;
    localparam logic [3:0] MODE_TURN_LEFT  = 4'd8;
    localparam logic [3:0] MODE_TURN_RIGHT = 4'd9;
    localparam logic [16:0] ONE_Q15        = 17'd32768;
    localparam logic [15:0] SPEED_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_MODE   = 2'd0,
        KIND_LIMIT  = 2'd1,
        KIND_MOTION = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        OP_PLAIN = 2'd0,
        OP_TANK  = 2'd1,
        OP_DRIVE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CFG_STICK_DZ   = 3'd0,
        CFG_SIDE_DZ    = 3'd1,
        CFG_TURN_THR   = 3'd2,
        CFG_LIN_SCALE  = 3'd3,
        CFG_ANG_SCALE  = 3'd4,
        CFG_CTRL_SEL   = 3'd5,
        CFG_MODE_TABLE = 3'd6,
        CFG_RESTORE    = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MODE,
        F_LIMIT,
        F_TURN,
        F_TANK,
        F_EN,
        F_MOTION
    } fstate_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_SAT,
        B_DONE
    } bstate_t;

    typedef struct packed {
        logic [14:0] stick_dz;
        logic [14:0] side_dz;
        logic [14:0] turn_thr;
        logic [15:0] lin_scale;
        logic [15:0] ang_scale;
        logic [12:0] ctrl_sel;
        logic [39:0] mode_table;
        logic [2:0]  restore;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        stick_dz:   15'd4915,
        side_dz:    15'd6554,
        turn_thr:   15'd16384,
        lin_scale:  16'd32768,
        ang_scale:  16'd32768,
        ctrl_sel:   13'd1017,
        mode_table: 40'd0,
        restore:    3'd0
    };

    // one request from front to back
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  mode_id;
        logic        limit_on;
        logic        last;
        op_t         op;
        logic        lin_en;
        logic        ang_en;
        logic [15:0] lin_axis;
        logic [15:0] ang_axis;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  mode_id;
        logic        limit_on;
        logic [16:0] lin;
        logic [16:0] ang;
        logic        last;
    } result_t;

    function automatic logic [15:0] mag16(input logic [15:0] v);
        return v[15] ? 16'(~v + 16'd1) : v;
    endfunction

endpackage

>>> hw/rtl/jdcm_queue.sv
// jdcm_queue: short request queue between the front and back parts
// depends on jdcm_pkg

module jdcm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  jdcm_pkg::entry_t wr_data,
    output logic            full,
    input  logic            rd,
    output jdcm_pkg::entry_t rd_data,
    output logic            empty
);
    import jdcm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/jdcm_front.sv
// jdcm_front: takes samples, walks modes, limit, tank turn and enable, queues requests
// depends on jdcm_pkg; feeds jdcm_queue

module jdcm_front #(
    parameter int MODE_SLOTS  = jdcm_pkg::MODE_SLOTS_DEF,
    parameter int NUM_BUTTONS = jdcm_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_AXES    = jdcm_pkg::NUM_AXES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  jdcm_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [15:0]      axis_side,
    input  logic [15:0]      axis_forward,
    input  logic [15:0]      axis_twist,
    input  logic [15:0]      axis_slider,
    input  logic [2:0]       axis_count,
    input  logic [11:0]      button_mask,
    input  logic [3:0]       button_count,
    input  logic             q_full,
    output logic             q_wr,
    output jdcm_pkg::entry_t q_data
);
    import jdcm_pkg::*;

    localparam logic [2:0] SLOT_LAST = 3'(MODE_SLOTS - 1);

    fstate_t     fst_reg, fst_next;
    logic [2:0]  slot_reg, slot_next;
    logic        ta_reg, ta_next;
    dir_t        dir_reg, dir_next;
    logic        lim_prev_reg, lim_prev_next;
    logic        lim_act_reg, lim_act_next;
    logic        drv_reg, drv_next;
    logic        en_prev_reg, en_prev_next;

    logic [15:0] side_reg, fwd_reg, twist_reg, slider_reg;
    logic [2:0]  naxes_reg;
    logic [11:0] mask_reg;
    logic [3:0]  nbtn_reg;

    logic        push;
    entry_t      ent;
    logic [5:0]  slot_base;
    logic [4:0]  slot;
    logic        hit;
    logic        lim_now;
    logic        engage;
    dir_t        want;
    logic        en_pr;
    logic        new_en;
    logic [4:0]  en_btn;
    logic [1:0]  sel_lin, sel_ang;

    function automatic logic pressed(input logic [4:0] i, input logic [11:0] m,
                                     input logic [3:0] n);
        logic [15:0] me;
        me = {4'b0, m};
        return ({1'b0, n} > i) && (i < 5'(NUM_BUTTONS)) && (i < BUTTON_LIMIT)
               && me[i[3:0]];
    endfunction

    function automatic logic [15:0] pick(input logic [1:0] s, input logic [15:0] a0,
                                         input logic [15:0] a1, input logic [15:0] a2,
                                         input logic [15:0] a3);
        logic [15:0] r;
        case (s)
            2'd0:    r = a0;
            2'd1:    r = a1;
            2'd2:    r = a2;
            default: r = a3;
        endcase
        return r;
    endfunction

    assign in_stall  = (fst_reg != F_IDLE);
    assign q_wr      = push && !q_full;
    assign q_data    = ent;
    assign slot_base = 6'(slot_reg) * 6'd5;
    assign slot      = cfg.mode_table[slot_base +: 5];
    assign hit       = slot[4] && pressed({1'b0, slot[3:0]}, mask_reg, nbtn_reg);
    assign lim_now   = pressed(LIMIT_BUTTON, mask_reg, nbtn_reg);
    assign en_btn    = cfg.ctrl_sel[8:4];
    assign en_pr     = pressed(en_btn, mask_reg, nbtn_reg);
    assign new_en    = drv_reg ^ (en_pr && !en_prev_reg);
    assign sel_lin   = cfg.ctrl_sel[1:0];
    assign sel_ang   = cfg.ctrl_sel[3:2];
    assign engage    = pressed({1'b0, cfg.ctrl_sel[12:9]}, mask_reg, nbtn_reg)
                       && (mag16(side_reg) < {1'b0, cfg.side_dz})
                       && (mag16(fwd_reg) <= {1'b0, cfg.stick_dz})
                       && (mag16(twist_reg) > {1'b0, cfg.turn_thr});
    assign want      = (!twist_reg[15] && twist_reg != '0) ? DIR_LEFT : DIR_RIGHT;

    // next state
    always_comb
    begin
        fst_next = fst_reg;
        case (fst_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    fst_next = F_MODE;
                end
            end
            F_MODE:
            begin
                if ((!hit || !q_full) && slot_reg == SLOT_LAST)
                begin
                    fst_next = F_LIMIT;
                end
            end
            F_LIMIT:
            begin
                if (!(lim_now && !lim_prev_reg) || !q_full)
                begin
                    fst_next = F_TURN;
                end
            end
            F_TURN:
            begin
                if (naxes_reg > 3'd2 && engage)
                begin
                    if (!((!ta_reg || dir_reg != want) && q_full))
                    begin
                        fst_next = F_TANK;
                    end
                end
                else if (!(naxes_reg > 3'd2 && ta_reg && q_full))
                begin
                    fst_next = F_EN;
                end
            end
            F_TANK:
            begin
                if (!q_full)
                begin
                    fst_next = F_IDLE;
                end
            end
            F_EN:
            begin
                if (en_btn >= ENABLE_OFF_MIN || new_en)
                begin
                    fst_next = F_MOTION;
                end
                else if (!q_full)
                begin
                    fst_next = F_IDLE;
                end
            end
            F_MOTION:
            begin
                if (!q_full)
                begin
                    fst_next = F_IDLE;
                end
            end
            default:
            begin
                fst_next = F_IDLE;
            end
        endcase
    end

    // requests and state updates
    always_comb
    begin
        push          = 1'b0;
        ent           = '0;
        ent.kind      = KIND_MODE;
        ent.op        = OP_PLAIN;
        slot_next     = slot_reg;
        ta_next       = ta_reg;
        dir_next      = dir_reg;
        lim_prev_next = lim_prev_reg;
        lim_act_next  = lim_act_reg;
        drv_next      = drv_reg;
        en_prev_next  = en_prev_reg;
        case (fst_reg)
            F_IDLE:
            begin
                slot_next = '0;
            end
            F_MODE:
            begin
                ent.mode_id = {1'b0, slot_reg};
                if (hit)
                begin
                    push = 1'b1;
                    if (!q_full)
                    begin
                        ta_next = 1'b0;
                    end
                end
                if (!hit || !q_full)
                begin
                    slot_next = slot_reg + 3'd1;
                end
            end
            F_LIMIT:
            begin
                ent.kind     = KIND_LIMIT;
                ent.limit_on = !lim_act_reg;
                if (lim_now && !lim_prev_reg)
                begin
                    push = 1'b1;
                    if (!q_full)
                    begin
                        lim_act_next  = !lim_act_reg;
                        lim_prev_next = lim_now;
                    end
                end
                else
                begin
                    lim_prev_next = lim_now;
                end
            end
            F_TURN:
            begin
                if (naxes_reg > 3'd2 && engage)
                begin
                    ent.mode_id = (want == DIR_LEFT) ? MODE_TURN_LEFT : MODE_TURN_RIGHT;
                    if (!ta_reg || dir_reg != want)
                    begin
                        push = 1'b1;
                        if (!q_full)
                        begin
                            ta_next  = 1'b1;
                            dir_next = want;
                        end
                    end
                end
                else if (naxes_reg > 3'd2 && ta_reg)
                begin
                    ent.mode_id = {1'b0, cfg.restore};
                    push        = 1'b1;
                    if (!q_full)
                    begin
                        ta_next  = 1'b0;
                        dir_next = DIR_NONE;
                    end
                end
            end
            F_TANK:
            begin
                push         = 1'b1;
                ent.kind     = KIND_MOTION;
                ent.op       = OP_TANK;
                ent.last     = 1'b1;
                ent.lin_en   = 1'b1;
                ent.lin_axis = twist_reg;
            end
            F_EN:
            begin
                ent.kind = KIND_MOTION;
                ent.last = 1'b1;
                if (en_btn < ENABLE_OFF_MIN)
                begin
                    if (new_en)
                    begin
                        drv_next     = new_en;
                        en_prev_next = en_pr;
                    end
                    else
                    begin
                        push = 1'b1;
                        if (!q_full)
                        begin
                            drv_next     = new_en;
                            en_prev_next = en_pr;
                        end
                    end
                end
            end
            F_MOTION:
            begin
                push         = 1'b1;
                ent.kind     = KIND_MOTION;
                ent.op       = OP_DRIVE;
                ent.last     = 1'b1;
                ent.lin_en   = {1'b0, sel_lin} < naxes_reg;
                ent.ang_en   = {1'b0, sel_ang} < naxes_reg;
                ent.lin_axis = pick(sel_lin, side_reg, fwd_reg, twist_reg, slider_reg);
                ent.ang_axis = pick(sel_ang, side_reg, fwd_reg, twist_reg, slider_reg);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fst_reg      <= F_IDLE;
            slot_reg     <= '0;
            ta_reg       <= 1'b0;
            dir_reg      <= DIR_NONE;
            lim_prev_reg <= 1'b0;
            lim_act_reg  <= 1'b0;
            drv_reg      <= 1'b0;
            en_prev_reg  <= 1'b0;
        end
        else
        begin
            fst_reg      <= fst_next;
            slot_reg     <= slot_next;
            ta_reg       <= ta_next;
            dir_reg      <= dir_next;
            lim_prev_reg <= lim_prev_next;
            lim_act_reg  <= lim_act_next;
            drv_reg      <= drv_next;
            en_prev_reg  <= en_prev_next;
        end
    end

    // sample capture
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            side_reg   <= axis_side;
            fwd_reg    <= axis_forward;
            twist_reg  <= axis_twist;
            slider_reg <= axis_slider;
            naxes_reg  <= (axis_count > 3'(NUM_AXES)) ? 3'(NUM_AXES) : axis_count;
            mask_reg   <= button_mask;
            nbtn_reg   <= button_count;
        end
    end

endmodule

>>> hw/rtl/jdcm_back.sv
// jdcm_back: executes queued requests, scales speeds with a serial divider
// depends on jdcm_pkg; drains jdcm_queue into the output register

module jdcm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  jdcm_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  jdcm_pkg::entry_t  q_data,
    output logic              q_rd,
    output logic              out_valid,
    input  logic              out_stall,
    output jdcm_pkg::result_t res
);
    import jdcm_pkg::*;

    bstate_t     bst_reg, bst_next;
    entry_t      work_reg;
    logic        phase_reg;
    logic [31:0] num_reg;
    logic [15:0] rem_reg;
    logic [15:0] den_reg;
    logic [4:0]  cnt_reg;
    logic [16:0] lin_res_reg, ang_res_reg;
    result_t     out_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic        load_plain;
    logic        load_motion;
    logic [15:0] cur_axis;
    logic        cur_en;
    logic [15:0] cur_scale;
    logic [15:0] a;
    logic        above;
    logic [15:0] mul_in;
    logic [31:0] prod;
    logic [16:0] trial;
    logic        ge;
    logic [15:0] qsat;
    logic        neg;
    logic [16:0] signed_q;
    logic [16:0] tank_q;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign res       = out_reg;

    assign cur_axis  = phase_reg ? work_reg.ang_axis : work_reg.lin_axis;
    assign cur_en    = phase_reg ? work_reg.ang_en : work_reg.lin_en;
    assign cur_scale = phase_reg ? cfg.ang_scale : cfg.lin_scale;
    assign a         = mag16(cur_axis);
    assign above     = a > {1'b0, cfg.stick_dz};
    assign mul_in    = (work_reg.op == OP_TANK) ? a : a - {1'b0, cfg.stick_dz};
    assign prod      = 32'(mul_in) * 32'(cur_scale);
    assign tank_q    = prod[31:15];
    assign trial     = {rem_reg, num_reg[31]};
    assign ge        = trial >= {1'b0, den_reg};
    assign qsat      = (num_reg[31:16] != '0) ? SPEED_MAX : num_reg[15:0];
    assign neg       = phase_reg ? cur_axis[15] : !cur_axis[15];
    assign signed_q  = neg ? 17'(~{1'b0, qsat} + 17'd1) : {1'b0, qsat};

    // next state
    always_comb
    begin
        bst_next = bst_reg;
        case (bst_reg)
            B_IDLE:
            begin
                if (!q_empty && q_data.op != OP_PLAIN)
                begin
                    bst_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (work_reg.op == OP_TANK || (phase_reg && !(cur_en && above)))
                begin
                    bst_next = B_DONE;
                end
                else if (cur_en && above)
                begin
                    bst_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (cnt_reg == 5'd31)
                begin
                    bst_next = B_SAT;
                end
            end
            B_SAT:
            begin
                bst_next = phase_reg ? B_DONE : B_MUL;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    bst_next = B_IDLE;
                end
            end
            default:
            begin
                bst_next = B_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        load_plain  = 1'b0;
        load_motion = 1'b0;
        q_rd        = 1'b0;
        case (bst_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.op == OP_PLAIN)
                    begin
                        load_plain = out_free;
                        q_rd       = out_free;
                    end
                    else
                    begin
                        q_rd = 1'b1;
                    end
                end
            end
            B_DONE:
            begin
                load_motion = out_free;
            end
            default:
            begin
                q_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_reg       <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bst_reg <= bst_next;
            if (load_plain || load_motion)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (bst_reg)
            B_IDLE:
            begin
                work_reg    <= q_data;
                phase_reg   <= 1'b0;
                lin_res_reg <= '0;
                ang_res_reg <= '0;
            end
            B_MUL:
            begin
                num_reg <= prod;
                rem_reg <= '0;
                den_reg <= 16'(ONE_Q15 - {2'b0, cfg.stick_dz});
                cnt_reg <= '0;
                if (work_reg.op == OP_TANK)
                begin
                    lin_res_reg <= tank_q[16] ? {1'b0, SPEED_MAX} : tank_q;
                end
                else if (!(cur_en && above))
                begin
                    phase_reg <= 1'b1;
                end
            end
            B_DIV:
            begin
                rem_reg <= ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
                num_reg <= {num_reg[30:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
            end
            B_SAT:
            begin
                if (phase_reg)
                begin
                    ang_res_reg <= signed_q;
                end
                else
                begin
                    lin_res_reg <= signed_q;
                end
                phase_reg <= 1'b1;
            end
            default:
            begin
                phase_reg <= phase_reg;
            end
        endcase

        if (load_plain)
        begin
            out_reg.kind     <= q_data.kind;
            out_reg.mode_id  <= q_data.mode_id;
            out_reg.limit_on <= q_data.limit_on;
            out_reg.lin      <= '0;
            out_reg.ang      <= '0;
            out_reg.last     <= q_data.last;
        end
        else if (load_motion)
        begin
            out_reg.kind     <= KIND_MOTION;
            out_reg.mode_id  <= '0;
            out_reg.limit_on <= 1'b0;
            out_reg.lin      <= lin_res_reg;
            out_reg.ang      <= ang_res_reg;
            out_reg.last     <= 1'b1;
        end
    end

endmodule

>>> hw/rtl/joystick_drive_command_mapper_unit.sv
// joystick_drive_command_mapper_unit: top level, configuration registers and the three parts
// depends on jdcm_pkg, jdcm_front, jdcm_queue, jdcm_back
// each scaled speed takes a 32-step serial divide in the back part; the front stalls its input until
// it has queued every request of the current sample, and the back takes one request at a time
// reset: asynchronous active low, clears all toggle and turn state and loads register defaults

module joystick_drive_command_mapper_unit #(
    parameter int MODE_SLOTS  = jdcm_pkg::MODE_SLOTS_DEF,
    parameter int NUM_BUTTONS = jdcm_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_AXES    = jdcm_pkg::NUM_AXES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jdcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [jdcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     axis_side,
    input  logic [15:0]                     axis_forward,
    input  logic [15:0]                     axis_twist,
    input  logic [15:0]                     axis_slider,
    input  logic [2:0]                      axis_count,
    input  logic [11:0]                     button_mask,
    input  logic [3:0]                      button_count,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      result_kind,
    output logic [3:0]                      mode_id,
    output logic                            limit_on,
    output logic [16:0]                     linear_speed,
    output logic [16:0]                     angular_speed,
    output logic                            last_result
);
    import jdcm_pkg::*;

    cfg_t    cfg_reg;
    logic    q_wr, q_rd, q_full, q_empty;
    entry_t  q_wdata, q_rdata;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STICK_DZ:   cfg_reg.stick_dz   <= cfg_data[14:0];
                CFG_SIDE_DZ:    cfg_reg.side_dz    <= cfg_data[14:0];
                CFG_TURN_THR:   cfg_reg.turn_thr   <= cfg_data[14:0];
                CFG_LIN_SCALE:  cfg_reg.lin_scale  <= cfg_data[15:0];
                CFG_ANG_SCALE:  cfg_reg.ang_scale  <= cfg_data[15:0];
                CFG_CTRL_SEL:   cfg_reg.ctrl_sel   <= cfg_data[12:0];
                CFG_MODE_TABLE: cfg_reg.mode_table <= cfg_data[39:0];
                CFG_RESTORE:    cfg_reg.restore    <= cfg_data[2:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    jdcm_front #(
        .MODE_SLOTS  (MODE_SLOTS),
        .NUM_BUTTONS (NUM_BUTTONS),
        .NUM_AXES    (NUM_AXES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .axis_side    (axis_side),
        .axis_forward (axis_forward),
        .axis_twist   (axis_twist),
        .axis_slider  (axis_slider),
        .axis_count   (axis_count),
        .button_mask  (button_mask),
        .button_count (button_count),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_data       (q_wdata)
    );

    jdcm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    jdcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_rd      (q_rd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign result_kind   = res.kind;
    assign mode_id       = res.mode_id;
    assign limit_on      = res.limit_on;
    assign linear_speed  = res.lin;
    assign angular_speed = res.ang;
    assign last_result   = res.last;

endmodule

>>> dv/tb.sv
// tb: self-checking testbench for joystick_drive_command_mapper_unit
// depends on jdcm_pkg and the rtl of the block; a scoreboard class predicts every result
`timescale 1ns / 100ps

module tb;
    import jdcm_pkg::*;

    typedef struct packed {
        logic [15:0] side;
        logic [15:0] fwd;
        logic [15:0] twist;
        logic [15:0] slider;
        logic [2:0]  naxes;
        logic [11:0] mask;
        logic [3:0]  nbtn;
    } sample_t;

    class mapper_scoreboard;
        cfg_t      cfg;
        bit        turn_on;
        dir_t      turn_dir;
        bit        lim_prev;
        bit        lim_on;
        bit        drive_on;
        bit        en_prev;
        result_t   pending[$];
        int        fails;

        function new();
            cfg      = CFG_RESET;
            turn_on  = 1'b0;
            turn_dir = DIR_NONE;
            lim_prev = 1'b0;
            lim_on   = 1'b0;
            drive_on = 1'b0;
            en_prev  = 1'b0;
            fails    = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [39:0] v);
            case (idx)
                CFG_STICK_DZ:   cfg.stick_dz   = v[14:0];
                CFG_SIDE_DZ:    cfg.side_dz    = v[14:0];
                CFG_TURN_THR:   cfg.turn_thr   = v[14:0];
                CFG_LIN_SCALE:  cfg.lin_scale  = v[15:0];
                CFG_ANG_SCALE:  cfg.ang_scale  = v[15:0];
                CFG_CTRL_SEL:   cfg.ctrl_sel   = v[12:0];
                CFG_MODE_TABLE: cfg.mode_table = v;
                CFG_RESTORE:    cfg.restore    = v[2:0];
                default: ;
            endcase
        endfunction

        function bit pressed(int unsigned i, sample_t s);
            if (i >= s.nbtn || i >= 12)
                return 1'b0;
            return s.mask[i];
        endfunction

        function int unsigned mag(logic [15:0] v);
            return v[15] ? 32'd65536 - v : v;
        endfunction

        function int rescale(logic [15:0] v, int unsigned dz, int unsigned gain);
            longint unsigned a;
            longint unsigned q;
            a = mag(v);
            if (a <= dz)
                return 0;
            q = ((a - dz) * gain) / (32768 - dz);
            if (q > 65535)
                q = 65535;
            return v[15] ? -int'(q) : int'(q);
        endfunction

        function void push(kind_t k, logic [3:0] m, bit l, int lin, int ang, bit last);
            result_t r;
            r.kind     = k;
            r.mode_id  = m;
            r.limit_on = l;
            r.lin      = lin[16:0];
            r.ang      = ang[16:0];
            r.last     = last;
            pending = {pending, r};
        endfunction

        function void note_sample(sample_t s);
            logic [15:0]     ax[4];
            logic [4:0]      slot;
            int unsigned     na;
            int unsigned     tw;
            longint unsigned q;
            int              lin;
            int              ang;
            bit              now;
            bit              held;
            bit              centred;
            dir_t            want;
            ax[0] = s.side;
            ax[1] = s.fwd;
            ax[2] = s.twist;
            ax[3] = s.slider;
            na = (s.naxes > 4) ? 4 : s.naxes;
            lin = 0;
            ang = 0;
            for (int k = 0; k < 8; k++)
            begin
                slot = cfg.mode_table[5*k +: 5];
                if (slot[4] && pressed(slot[3:0], s))
                begin
                    push(KIND_MODE, 4'(k), 1'b0, 0, 0, 1'b0);
                    turn_on = 1'b0;
                end
            end
            now = pressed(LIMIT_BUTTON, s);
            if (now && !lim_prev)
            begin
                lim_on = !lim_on;
                push(KIND_LIMIT, 4'd0, lim_on, 0, 0, 1'b0);
            end
            lim_prev = now;
            if (na > 2)
            begin
                held = pressed(cfg.ctrl_sel[12:9], s);
                centred = mag(ax[0]) < cfg.side_dz && mag(ax[1]) <= cfg.stick_dz;
                tw = mag(ax[2]);
                if (held && centred && tw > cfg.turn_thr)
                begin
                    want = ($signed(ax[2]) > 0) ? DIR_LEFT : DIR_RIGHT;
                    if (!turn_on || turn_dir != want)
                    begin
                        push(KIND_MODE, (want == DIR_LEFT) ? MODE_TURN_LEFT : MODE_TURN_RIGHT,
                             1'b0, 0, 0, 1'b0);
                        turn_on  = 1'b1;
                        turn_dir = want;
                    end
                    q = (longint'(tw) * cfg.lin_scale) / 32768;
                    if (q > 65535)
                        q = 65535;
                    push(KIND_MOTION, 4'd0, 1'b0, int'(q), 0, 1'b1);
                    return;
                end
                else if (turn_on)
                begin
                    push(KIND_MODE, {1'b0, cfg.restore}, 1'b0, 0, 0, 1'b0);
                    turn_on  = 1'b0;
                    turn_dir = DIR_NONE;
                end
            end
            if (cfg.ctrl_sel[8:4] < ENABLE_OFF_MIN)
            begin
                now = pressed(cfg.ctrl_sel[8:4], s);
                if (now && !en_prev)
                    drive_on = !drive_on;
                en_prev = now;
                if (!drive_on)
                begin
                    push(KIND_MOTION, 4'd0, 1'b0, 0, 0, 1'b1);
                    return;
                end
            end
            if (cfg.ctrl_sel[1:0] < na)
                lin = -rescale(ax[cfg.ctrl_sel[1:0]], cfg.stick_dz, cfg.lin_scale);
            if (cfg.ctrl_sel[3:2] < na)
                ang = rescale(ax[cfg.ctrl_sel[3:2]], cfg.stick_dz, cfg.ang_scale);
            push(KIND_MOTION, 4'd0, 1'b0, lin, ang, 1'b1);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result kind %0d", got.kind);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.mode_id !== want.mode_id ||
                got.limit_on !== want.limit_on || got.lin !== want.lin ||
                got.ang !== want.ang || got.last !== want.last)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("mismatch exp kind %0d mode %0d lim %0d lin %0d ang %0d last %0d",
                             want.kind, want.mode_id, want.limit_on, $signed(want.lin),
                             $signed(want.ang), want.last);
                    $display("         got kind %0d mode %0d lim %0d lin %0d ang %0d last %0d",
                             got.kind, got.mode_id, got.limit_on, $signed(got.lin),
                             $signed(got.ang), got.last);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [39:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] axis_side;
    logic [15:0] axis_forward;
    logic [15:0] axis_twist;
    logic [15:0] axis_slider;
    logic [2:0]  axis_count;
    logic [11:0] button_mask;
    logic [3:0]  button_count;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [3:0]  mode_id;
    logic        limit_on;
    logic [16:0] linear_speed;
    logic [16:0] angular_speed;
    logic        last_result;

    mapper_scoreboard sb = new();
    int send_idle;
    int recv_idle;
    int quiet;

    joystick_drive_command_mapper_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .axis_side    (axis_side),
        .axis_forward (axis_forward),
        .axis_twist   (axis_twist),
        .axis_slider  (axis_slider),
        .axis_count   (axis_count),
        .button_mask  (button_mask),
        .button_count (button_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .mode_id      (mode_id),
        .limit_on     (limit_on),
        .linear_speed (linear_speed),
        .angular_speed(angular_speed),
        .last_result  (last_result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall = ($urandom_range(0, 99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{kind: kind_t'(result_kind), mode_id: mode_id,
                              limit_on: limit_on, lin: linear_speed,
                              ang: angular_speed, last: last_result});
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= 5000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [39:0] v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send(sample_t s);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        axis_side    = s.side;
        axis_forward = s.fwd;
        axis_twist   = s.twist;
        axis_slider  = s.slider;
        axis_count   = s.naxes;
        button_mask  = s.mask;
        button_count = s.nbtn;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    // hold off requests until every result is back, then let the back end settle
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(negedge clk);
    endtask

    function automatic sample_t mk(logic [15:0] sd, logic [15:0] fw, logic [15:0] tw,
                                   logic [15:0] sl, logic [2:0] na, logic [11:0] m,
                                   logic [3:0] nb);
        return '{side: sd, fwd: fw, twist: tw, slider: sl, naxes: na, mask: m, nbtn: nb};
    endfunction

    function automatic logic [15:0] small_axis(int unsigned lim);
        logic [15:0] v;
        v = 16'($urandom_range(0, lim));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic sample_t rand_sample();
        sample_t     s;
        int unsigned tb_btn;
        if ($urandom_range(0, 99) < 25)
            return mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      3'($urandom_range(0, 4)), 12'($urandom), 4'($urandom_range(0, 12)));
        s = mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               ($urandom_range(0, 9) < 8) ? 3'd4 : 3'($urandom_range(0, 4)), 12'd0,
               ($urandom_range(0, 9) < 8) ? 4'd12 : 4'($urandom_range(0, 12)));
        for (int i = 0; i < 12; i++)
            s.mask[i] = ($urandom_range(0, 7) == 0);
        tb_btn = sb.cfg.ctrl_sel[12:9];
        if (tb_btn < 12 && $urandom_range(0, 99) < 40)
            s.mask[tb_btn] = 1'b1;
        if ($urandom_range(0, 1))
        begin
            s.side = small_axis(sb.cfg.side_dz + 200);
            s.fwd  = small_axis(sb.cfg.stick_dz + 200);
        end
        if ($urandom_range(0, 1))
            s.twist = $urandom_range(0, 1) ? 16'($urandom_range(sb.cfg.turn_thr, 32767))
                                           : -16'($urandom_range(sb.cfg.turn_thr, 32768));
        return s;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send(rand_sample());
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_STICK_DZ;
        cfg_data     = '0;
        in_valid     = 1'b0;
        axis_side    = '0;
        axis_forward = '0;
        axis_twist   = '0;
        axis_slider  = '0;
        axis_count   = '0;
        button_mask  = '0;
        button_count = '0;
        out_stall    = 1'b0;
        send_idle    = 34;
        recv_idle    = 59;
        quiet        = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // linear forward, angular twist, enable button 5, turn button 1
        write_reg(CFG_CTRL_SEL, 40'd601);
        write_reg(CFG_MODE_TABLE, (40'd16 << 0) | (40'd23 << 15) | (40'd27 << 35));
        write_reg(CFG_RESTORE, 40'd5);
        send(mk(0, 0, 0, 0, 4, 0, 12));
        send(mk(0, 0, 0, 0, 4, 12'h020, 12));
        send(mk(16'h8000, 16'h7FFF, 0, 0, 4, 0, 12));
        send(mk(0, 16'h8000, 16'h7FFF, 16'h8000, 4, 0, 12));
        send(mk(0, 0, 16'h8000, 16'h7FFF, 4, 12'h010, 12));
        send(mk(0, 0, 0, 0, 4, 12'h010, 12));
        send(mk(0, 0, 0, 0, 4, 0, 12));
        send(mk(0, 0, 0, 0, 4, 12'h010, 12));
        send(mk(0, 0, 16'd20000, 0, 4, 12'h002, 12));
        send(mk(0, 0, -16'd20000, 0, 4, 12'h002, 12));
        send(mk(0, 0, 16'h8000, 0, 4, 12'h002, 12));
        send(mk(0, 0, 0, 0, 4, 0, 12));
        send(mk(0, 0, 0, 0, 4, 12'h881, 12));
        send(mk(0, 0, 0, 0, 4, 12'h881, 8));
        send(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4, 12'hFFF, 0));
        send(mk(16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234, 0, 0, 7));
        send(mk(16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234, 1, 0, 12));
        send(mk(16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234, 2, 0, 12));
        send(mk(0, 0, 16'd20000, 0, 3, 12'h003, 12));
        send(mk(16'd6554, 0, 16'd20000, 0, 4, 12'h002, 12));
        send(mk(0, 0, 0, 0, 4, 12'h020, 12));
        send(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4, 12'hFFF, 12));
        run_random(60);
        drain();

        send_idle = 59;
        recv_idle = 34;
        write_reg(CFG_STICK_DZ, 40'd0);
        write_reg(CFG_SIDE_DZ, 40'd32767);
        write_reg(CFG_TURN_THR, 40'd0);
        write_reg(CFG_LIN_SCALE, 40'd65535);
        write_reg(CFG_ANG_SCALE, 40'd65535);
        write_reg(CFG_CTRL_SEL, 40'd8191);
        write_reg(CFG_MODE_TABLE, 40'hFF_FFFF_FFFF);
        write_reg(CFG_RESTORE, 40'd7);
        run_random(35);
        drain();
        run_random(35);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_STICK_DZ, 40'd32767);
        write_reg(CFG_SIDE_DZ, 40'd0);
        write_reg(CFG_TURN_THR, 40'd32767);
        write_reg(CFG_LIN_SCALE, 40'd0);
        write_reg(CFG_ANG_SCALE, 40'd0);
        write_reg(CFG_CTRL_SEL, 40'd0);
        write_reg(CFG_MODE_TABLE, 40'd0);
        write_reg(CFG_RESTORE, 40'd0);
        run_random(50);
        drain();

        write_reg(CFG_STICK_DZ, 40'($urandom_range(0, 32767)));
        write_reg(CFG_SIDE_DZ, 40'($urandom_range(0, 32767)));
        write_reg(CFG_TURN_THR, 40'($urandom_range(0, 32767)));
        write_reg(CFG_LIN_SCALE, 40'($urandom_range(0, 65535)));
        write_reg(CFG_ANG_SCALE, 40'($urandom_range(0, 65535)));
        write_reg(CFG_CTRL_SEL, 40'($urandom_range(0, 8191)));
        write_reg(CFG_MODE_TABLE, {8'($urandom), 32'($urandom)});
        write_reg(CFG_RESTORE, 40'($urandom_range(0, 7)));
        run_random(70);
        drain();

        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/jdcm_pkg.sv
hw/rtl/jdcm_queue.sv
hw/rtl/jdcm_front.sv
hw/rtl/jdcm_back.sv
hw/rtl/joystick_drive_command_mapper_unit.sv
dv/tb.sv
